[rtl/core/tsfe_pkg.sv]
// shared types, codes and defaults for the tlv stream field extractor
package tsfe_pkg;

  localparam int unsigned DEF_LENGTH_BITS = 32;
  localparam int unsigned DEF_VALUE_BITS  = 32;

  localparam int unsigned CFG_IDX_BITS = 8;
  localparam int unsigned RES_BITS     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_TYPE = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_TYPE   = 8'd1;

  localparam logic [7:0] MATCH_TYPE_RST = 8'h01;
  localparam logic [7:0] END_TYPE_RST   = 8'h00;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_LENLEN  = 3'd2,
    PH_VALUE   = 3'd3,
    PH_CONFIRM = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [RES_BITS-1:0] field_value;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0] index;
    logic [7:0]              data;
  } cfg_t;

endpackage

[rtl/core/tsfe_stream_if.sv]
// valid/ready channel carrying one payload word
interface tsfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/tsfe_in_reg.sv]
// input register stage for packet bytes
module tsfe_in_reg (
  input  logic         clk_i,
  input  logic         rst_ni,
  tsfe_stream_if.sink  in_i,
  input  logic         take_i,
  output logic         valid_o,
  output tsfe_pkg::in_t word_o
);
  import tsfe_pkg::*;

  logic valid_q;
  in_t  word_q;

  // refill in the same cycle the held word is consumed
  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      word_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule

[rtl/core/tsfe_out_reg.sv]
// result register driving the output channel
module tsfe_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsfe_pkg::res_t res_i,
  output logic           space_o,
  tsfe_stream_if.source  out_o
);
  import tsfe_pkg::*;

  logic valid_q;
  res_t res_q;

  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = res_q;
endmodule

[rtl/core/tsfe_parser.sv]
// tlv parse state, config registers and result decision for one byte
module tsfe_parser #(
  parameter int unsigned LENGTH_BITS = tsfe_pkg::DEF_LENGTH_BITS,
  parameter int unsigned VALUE_BITS  = tsfe_pkg::DEF_VALUE_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tsfe_stream_if.sink    cfg_i,
  input  logic           take_i,
  input  tsfe_pkg::in_t  word_i,
  output logic           emit_o,
  output tsfe_pkg::res_t res_o
);
  import tsfe_pkg::*;

  logic [7:0]             match_q;
  logic [7:0]             end_q;
  phase_e                 phase_q, phase_d;
  logic [6:0]             len_left_q, len_left_d;
  logic [LENGTH_BITS-1:0] vleft_q, vleft_d, vleft_shift;
  logic                   match_hit_q, match_hit_d;
  logic [VALUE_BITS-1:0]  accum_q, accum_d, accum_shift;
  logic                   done_q, done_d;
  logic                   emit, hit;
  logic [7:0]             b;
  logic                   last;

  assign b    = word_i.byte_in;
  assign last = word_i.last_byte;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= MATCH_TYPE_RST;
      end_q   <= END_TYPE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_MATCH_TYPE: match_q <= cfg_i.payload.data;
        CFG_END_TYPE:   end_q   <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  // big-endian fold, wrapping to the register width
  assign vleft_shift = LENGTH_BITS'({vleft_q, b});
  assign accum_shift = VALUE_BITS'({accum_q, b});

  always_comb begin
    phase_d     = phase_q;
    len_left_d  = len_left_q;
    vleft_d     = vleft_q;
    match_hit_d = match_hit_q;
    accum_d     = accum_q;
    done_d      = done_q;
    emit        = 1'b0;
    hit         = 1'b0;
    if (take_i && !done_q) begin
      unique case (phase_q)
        PH_TYPE: begin
          if (b == end_q) begin
            emit = 1'b1;
          end else begin
            match_hit_d = (b == match_q);
            phase_d     = PH_LEN;
          end
        end
        PH_LEN: begin
          accum_d = '0;
          if (b[7]) begin
            len_left_d = b[6:0];
            vleft_d    = '0;
            if (b[6:0] == 7'd0) begin
              phase_d = match_hit_q ? PH_CONFIRM : PH_TYPE;
            end else begin
              phase_d = PH_LENLEN;
            end
          end else begin
            vleft_d = LENGTH_BITS'(b);
            if (b == 8'd0) begin
              phase_d = match_hit_q ? PH_CONFIRM : PH_TYPE;
            end else begin
              phase_d = PH_VALUE;
            end
          end
        end
        PH_LENLEN: begin
          vleft_d    = vleft_shift;
          len_left_d = len_left_q - 7'd1;
          if (len_left_q == 7'd1) begin
            accum_d = '0;
            if (vleft_shift == '0) begin
              phase_d = match_hit_q ? PH_CONFIRM : PH_TYPE;
            end else begin
              phase_d = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          if (match_hit_q) begin
            accum_d = accum_shift;
          end
          vleft_d = vleft_q - LENGTH_BITS'(1);
          if (vleft_q == LENGTH_BITS'(1)) begin
            phase_d = match_hit_q ? PH_CONFIRM : PH_TYPE;
          end
        end
        PH_CONFIRM: begin
          // follower byte after a complete matching value
          emit = 1'b1;
          hit  = 1'b1;
        end
        default: phase_d = PH_TYPE;
      endcase
      if (last) begin
        emit = 1'b1;
      end
      if (emit) begin
        done_d = 1'b1;
      end
    end
    // end of packet clears the per-packet state
    if (take_i && last) begin
      phase_d     = PH_TYPE;
      len_left_d  = '0;
      vleft_d     = '0;
      match_hit_d = 1'b0;
      accum_d     = '0;
      done_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TYPE;
      len_left_q  <= '0;
      vleft_q     <= '0;
      match_hit_q <= 1'b0;
      accum_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      vleft_q     <= vleft_d;
      match_hit_q <= match_hit_d;
      accum_q     <= accum_d;
      done_q      <= done_d;
    end
  end

  assign emit_o            = emit;
  assign res_o.found       = hit;
  assign res_o.field_value = hit ? RES_BITS'(accum_q) : '0;

`ifndef ASSERT_OFF
  a_no_emit_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !done_q)
    else $error("result emitted after packet already answered");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && last) |=> (phase_q == PH_TYPE && !done_q && !match_hit_q))
    else $error("packet state not cleared after last word");

  a_lenlen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LENLEN) |-> (len_left_q != 7'd0))
    else $error("length byte count exhausted in length phase");

  a_confirm_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CONFIRM) |-> match_hit_q)
    else $error("confirm phase without a matching entry");

  a_value_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VALUE) |-> (vleft_q != '0))
    else $error("value phase with no bytes left");
`endif
endmodule

[rtl/core/tlv_stream_field_extractor.sv]
// top level: byte-wise tlv scan returning the value of the first matching entry
// path: input register holds each byte; its result is registered in the output register
// throughput: one byte per cycle if out_o has space, set by the single parse-state update
// results: one word per packet, held in the output register; bytes stall until it is taken
// reset: parse state idle at type byte, match_type = 1, end_type = 0, both registers empty
module tlv_stream_field_extractor #(
  parameter int unsigned LENGTH_BITS = tsfe_pkg::DEF_LENGTH_BITS,
  parameter int unsigned VALUE_BITS  = tsfe_pkg::DEF_VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsfe_stream_if.sink   in_i,
  tsfe_stream_if.sink   cfg_i,
  tsfe_stream_if.source out_o
);
  import tsfe_pkg::*;

  logic in_valid;
  in_t  in_word;
  logic space;
  logic take;
  logic emit;
  res_t res;

  assign take = in_valid && space;

  tsfe_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (in_valid),
    .word_o  (in_word)
  );

  tsfe_parser #(
    .LENGTH_BITS (LENGTH_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .take_i (take),
    .word_i (in_word),
    .emit_o (emit),
    .res_o  (res)
  );

  tsfe_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .res_i   (res),
    .space_o (space),
    .out_o   (out_o)
  );
endmodule
